// ===== hw/rtl/osfic_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osfic_pkg
// shared types, number formats and plant constants of the observer controller
// ----------------------------------------------------------------------------
package osfic_pkg;

    // number formats
    localparam int DW         = 48;   // data word, signed fixed point
    localparam int FRAC_BITS  = 24;   // fraction bits of a data word
    localparam int CONST_FRAC = 32;   // fraction bits of the plant constants
    localparam int ADC_BITS   = 12;
    localparam int DRIVE_W    = 47;
    localparam int PWM_W      = 16;
    localparam int CFG_IDX_W  = 3;

    // multiplier digit size, operand b is consumed one digit per cycle
    localparam int MUL_DIG = 24;
    localparam int MUL_ND  = (DW + MUL_DIG - 1) / MUL_DIG;
    localparam int MUL_BW  = MUL_ND * MUL_DIG;
    localparam int MUL_PW  = DW + MUL_BW;

    localparam logic signed [DW-1:0] D_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] D_MIN = {1'b1, {(DW-1){1'b0}}};

    // volts per count, 32 fraction bits
    localparam int ADC_K_W = 22;
    localparam logic [ADC_K_W-1:0] C_ADC_K = ADC_K_W'(3460301);

    // plant constants, 32 fraction bits
    localparam logic signed [DW-1:0] C_TS  = DW'(64'sd2147484);
    localparam logic signed [DW-1:0] C_A00 = DW'(64'sd416523780882);
    localparam logic signed [DW-1:0] C_A01 = DW'(64'sd38701520808);
    localparam logic signed [DW-1:0] C_A10 = DW'(-64'sd69487846385254);
    localparam logic signed [DW-1:0] C_A11 = DW'(-64'sd2863311530667);
    localparam logic signed [DW-1:0] C_B0  = DW'(64'sd51252274);
    localparam logic signed [DW-1:0] C_B1  = DW'(-64'sd3382517815);
    localparam logic signed [DW-1:0] C_F0  = DW'(64'sd0);
    localparam logic signed [DW-1:0] C_F1  = DW'(64'sd286332585);
    localparam logic signed [DW-1:0] C_D0  = DW'(-64'sd77258);
    localparam logic signed [DW-1:0] C_D1  = DW'(64'sd6948828);

    // register reset values
    localparam logic signed [DW-1:0] RST_REF_LOW  = DW'(64'sd16777216);
    localparam logic signed [DW-1:0] RST_REF_HIGH = DW'(64'sd25165824);
    localparam logic signed [DW-1:0] RST_KI       = DW'(64'sd23360595558);
    localparam logic signed [DW-1:0] RST_K1       = DW'(64'sd184274230);
    localparam logic signed [DW-1:0] RST_K2       = DW'(64'sd7838768300032);
    localparam logic signed [DW-1:0] RST_K3       = DW'(64'sd10484568818);
    localparam logic [DRIVE_W-1:0]   RST_DMAX     = DRIVE_W'(64'd55364813);
    localparam logic [DRIVE_W-1:0]   RST_PWM      = DRIVE_W'(64'd5078919623);
    localparam logic signed [DW-1:0] RST_ULAST    = DW'(64'sd1 <<< FRAC_BITS);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REF_LOW   = 3'd0,
        CFG_REF_HIGH  = 3'd1,
        CFG_KI        = 3'd2,
        CFG_K1        = 3'd3,
        CFG_K2        = 3'd4,
        CFG_K3        = 3'd5,
        CFG_DRIVE_MAX = 3'd6,
        CFG_PWM_SCALE = 3'd7
    } t_cfg_idx;

    // micro-operations
    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,   // take a sample word, form y and r
        OP_MOV,
        OP_ADD,
        OP_SUB,
        OP_MULQ,   // product shifted by the data fraction
        OP_MULC,   // product shifted by the constant fraction
        OP_EMIT    // hand the result word to the output register
    } t_op;

    typedef enum logic [1:0] {
        J_NEXT,
        J_GOTO,
        J_NEG,     // jump when operand a is negative
        J_LE       // jump when operand a <= operand b
    } t_jmp;

    typedef enum logic [4:0] {
        S_ZERO, S_Y, S_R, S_ETA0, S_ETA1, S_XI, S_ULAST,
        S_T0, S_T1, S_T2,
        S_KI, S_K1, S_K2, S_K3, S_DMAX, S_PWM,
        S_TS, S_A00, S_A01, S_A10, S_A11, S_B0, S_B1, S_F0, S_F1, S_D0, S_D1
    } t_src;

    typedef enum logic [2:0] {
        D_NONE, D_T0, D_T1, D_T2, D_ETA0, D_ETA1, D_XI, D_ULAST
    } t_dst;

    // one control word
    typedef struct packed {
        t_op  op;
        t_src src_a;
        t_src src_b;
        t_dst dst;
        t_jmp jmp;
        logic [5:0] target;
    } t_uword;

    // sequencer to datapath
    typedef struct packed {
        t_op  op;
        t_src src_a;
        t_src src_b;
        t_dst dst;
        logic commit;
    } t_ctrl;

    // datapath to sequencer
    typedef struct packed {
        logic mul_done;
        logic out_free;
        logic a_neg;
        logic a_le_b;
    } t_stat;

endpackage

// ===== hw/rtl/osfic_smp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osfic_smp_if
// sample channel: converter code and reference select
// ----------------------------------------------------------------------------
interface osfic_smp_if;
    logic                          valid;
    logic                          ready;
    logic [osfic_pkg::ADC_BITS-1:0] adc_sample;
    logic                          ref_select;

    modport source (output valid, output adc_sample, output ref_select, input ready);
    modport sink   (input valid, input adc_sample, input ref_select, output ready);
endinterface

// ===== hw/rtl/osfic_res_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osfic_res_if
// result channel: clamped drive and timer compare value
// ----------------------------------------------------------------------------
interface osfic_res_if;
    logic                          valid;
    logic                          ready;
    logic [osfic_pkg::DRIVE_W-1:0] drive_value;
    logic [osfic_pkg::PWM_W-1:0]   pwm_compare;

    modport source (output valid, output drive_value, output pwm_compare, input ready);
    modport sink   (input valid, input drive_value, input pwm_compare, output ready);
endinterface

// ===== hw/rtl/observer_state_feedback_integral_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// observer_state_feedback_integral_ctrl
// reduced-observer state feedback controller with integral action
// ----------------------------------------------------------------------------
// usage
//   i_smp carries one sample word per tick: a 12-bit converter code and the
//   reference select bit. o_res returns one word per sample: the clamped
//   drive u (Q23.24 volts) and the 16-bit timer compare value.
//   i_cfg_we / i_cfg_idx / i_cfg_data write the references, gains, drive
//   limit and pwm scale; write only while no sample is in flight.
// sequence
//   a sample is taken at the load step. an update walks 38 micro-steps (39
//   when the drive clamps at its limit), 18 of them multiplies (the 48-bit
//   multiplier takes 24 bits of one operand per cycle); the result word is
//   registered at the emit step, and only then does the program return to
//   the load step, so the next sample is taken after the previous result.
// reset
//   i_rst_n is synchronous, active low: observer states and integral clear,
//   the previous drive becomes 1.0, registers take their defaults and the
//   output word is dropped.
// stalls
//   the result sits in an output register; when the receiver holds off, the
//   program runs on to its next emit step and waits there until the held word is taken
// ----------------------------------------------------------------------------
module observer_state_feedback_integral_ctrl (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    osfic_smp_if.sink                        i_smp,
    osfic_res_if.source                      o_res,
    input  logic                             i_cfg_we,
    input  logic [osfic_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [osfic_pkg::DW-1:0]         i_cfg_data
);
    import osfic_pkg::*;

    t_ctrl ctrl;   // current control word, committed when not waiting
    t_stat stat;   // multiplier done, output free, compare flags

    // step counter and program
    osfic_useq u_useq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_smp.valid),
        .o_in_ready (i_smp.ready),
        .i_stat     (stat),
        .o_ctrl     (ctrl)
    );

    // registers, arithmetic and the output word
    osfic_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (ctrl),
        .o_stat        (stat),
        .i_adc_sample  (i_smp.adc_sample),
        .i_ref_select  (i_smp.ref_select),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_out_ready   (o_res.ready),
        .o_out_valid   (o_res.valid),
        .o_drive_value (o_res.drive_value),
        .o_pwm_compare (o_res.pwm_compare)
    );

endmodule

// ===== hw/rtl/osfic_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osfic_mul
// digit-serial signed multiplier with shift, truncation and saturation
// ----------------------------------------------------------------------------
module osfic_mul (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_req,
    input  logic                            i_sh_const,
    input  logic signed [osfic_pkg::DW-1:0] i_a,
    input  logic signed [osfic_pkg::DW-1:0] i_b,
    output logic                            o_done,
    output logic signed [osfic_pkg::DW-1:0] o_res
);
    import osfic_pkg::*;

    localparam int CNT_W = (MUL_ND > 1) ? $clog2(MUL_ND) : 1;

    typedef enum logic [2:0] {
        M_IDLE = 3'b001,
        M_RUN  = 3'b010,
        M_DONE = 3'b100
    } t_mstate;

    t_mstate            r_st, n_st;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [DW-1:0]      r_a, n_a;
    logic [MUL_BW-1:0]  r_b, n_b;
    logic [MUL_PW-1:0]  r_acc, n_acc;
    logic               r_neg, n_neg;
    logic               r_sh, n_sh;

    logic [DW-1:0]         a_mag, b_mag;
    logic [DW+MUL_DIG-1:0] part;
    logic [MUL_PW-1:0]     shifted;
    logic                  over;
    logic [DW-1:0]         mag;

    assign a_mag = i_a[DW-1] ? DW'(-i_a) : DW'(i_a);
    assign b_mag = i_b[DW-1] ? DW'(-i_b) : DW'(i_b);
    assign part  = (DW+MUL_DIG)'(r_a) * (DW+MUL_DIG)'(r_b[MUL_BW-1 -: MUL_DIG]);

    always_comb begin
        n_st  = r_st;
        n_cnt = r_cnt;
        n_a   = r_a;
        n_b   = r_b;
        n_acc = r_acc;
        n_neg = r_neg;
        n_sh  = r_sh;
        unique case (r_st)
            M_IDLE: begin
                if (i_req) begin
                    n_a   = a_mag;
                    n_b   = MUL_BW'(b_mag);
                    n_acc = '0;
                    n_neg = i_a[DW-1] ^ i_b[DW-1];
                    n_sh  = i_sh_const;
                    n_cnt = CNT_W'(MUL_ND - 1);
                    n_st  = M_RUN;
                end
            end
            M_RUN: begin
                // most significant digit first
                n_acc = (r_acc << MUL_DIG) + MUL_PW'(part);
                n_b   = r_b << MUL_DIG;
                if (r_cnt == '0) begin
                    n_st = M_DONE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            M_DONE: begin
                n_st = M_IDLE;
            end
            default: begin
                n_st = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= M_IDLE;
        end else begin
            r_st <= n_st;
        end
        r_cnt <= n_cnt;
        r_a   <= n_a;
        r_b   <= n_b;
        r_acc <= n_acc;
        r_neg <= n_neg;
        r_sh  <= n_sh;
    end

    // truncate the magnitude, saturate, then restore the sign
    always_comb begin
        if (r_sh) begin
            shifted = r_acc >> CONST_FRAC;
            over    = |r_acc[MUL_PW-1:CONST_FRAC+DW-1];
        end else begin
            shifted = r_acc >> FRAC_BITS;
            over    = |r_acc[MUL_PW-1:FRAC_BITS+DW-1];
        end
        mag = shifted[DW-1:0];
        if (over) begin
            o_res = r_neg ? D_MIN : D_MAX;
        end else begin
            o_res = r_neg ? DW'(-mag) : mag;
        end
    end

    assign o_done = (r_st == M_DONE);

endmodule

// ===== hw/rtl/osfic_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osfic_dp
// register file, configuration, multiplier, saturating adder and output register
// ----------------------------------------------------------------------------
module osfic_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  osfic_pkg::t_ctrl                      i_ctrl,
    output osfic_pkg::t_stat                      o_stat,
    input  logic [osfic_pkg::ADC_BITS-1:0]        i_adc_sample,
    input  logic                                  i_ref_select,
    input  logic                                  i_cfg_we,
    input  logic [osfic_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [osfic_pkg::DW-1:0]              i_cfg_data,
    input  logic                                  i_out_ready,
    output logic                                  o_out_valid,
    output logic [osfic_pkg::DRIVE_W-1:0]         o_drive_value,
    output logic [osfic_pkg::PWM_W-1:0]           o_pwm_compare
);
    import osfic_pkg::*;

    localparam int YP_W      = ADC_BITS + ADC_K_W;
    localparam int ADC_SHIFT = CONST_FRAC - FRAC_BITS;
    localparam int CNT_HI    = DW - FRAC_BITS;

    // configuration
    logic signed [DW-1:0] r_ref_low, r_ref_high, r_ki, r_k1, r_k2, r_k3;
    logic [DRIVE_W-1:0]   r_dmax, r_pwm_scale;

    // working registers
    logic signed [DW-1:0] r_y, r_r, r_eta0, r_eta1, r_xi, r_ulast;
    logic signed [DW-1:0] r_t0, r_t1, r_t2;

    logic                 r_out_valid;
    logic [DRIVE_W-1:0]   r_drive;
    logic [PWM_W-1:0]     r_pwm;

    logic signed [DW-1:0] a_val, b_val, wr_val, mul_res;
    logic signed [DW:0]   sum;
    logic                 mul_req, mul_done, out_free;
    logic [YP_W-1:0]      y_prod;
    logic [CNT_HI-1:0]    cnt_bits;

    function automatic logic signed [DW-1:0] sel_src(
        input t_src s,
        input logic signed [DW-1:0] y, r, e0, e1, xi, ul, t0, t1, t2,
        input logic signed [DW-1:0] ki, k1, k2, k3,
        input logic [DRIVE_W-1:0] dmax, pwm
    );
        logic signed [DW-1:0] v;
        case (s)
            S_ZERO:  v = '0;
            S_Y:     v = y;
            S_R:     v = r;
            S_ETA0:  v = e0;
            S_ETA1:  v = e1;
            S_XI:    v = xi;
            S_ULAST: v = ul;
            S_T0:    v = t0;
            S_T1:    v = t1;
            S_T2:    v = t2;
            S_KI:    v = ki;
            S_K1:    v = k1;
            S_K2:    v = k2;
            S_K3:    v = k3;
            S_DMAX:  v = DW'(dmax);
            S_PWM:   v = DW'(pwm);
            S_TS:    v = C_TS;
            S_A00:   v = C_A00;
            S_A01:   v = C_A01;
            S_A10:   v = C_A10;
            S_A11:   v = C_A11;
            S_B0:    v = C_B0;
            S_B1:    v = C_B1;
            S_F0:    v = C_F0;
            S_F1:    v = C_F1;
            S_D0:    v = C_D0;
            S_D1:    v = C_D1;
            default: v = '0;
        endcase
        return v;
    endfunction

    assign a_val = sel_src(i_ctrl.src_a, r_y, r_r, r_eta0, r_eta1, r_xi, r_ulast,
                           r_t0, r_t1, r_t2, r_ki, r_k1, r_k2, r_k3,
                           r_dmax, r_pwm_scale);
    assign b_val = sel_src(i_ctrl.src_b, r_y, r_r, r_eta0, r_eta1, r_xi, r_ulast,
                           r_t0, r_t1, r_t2, r_ki, r_k1, r_k2, r_k3,
                           r_dmax, r_pwm_scale);

    assign mul_req = (i_ctrl.op == OP_MULQ) || (i_ctrl.op == OP_MULC);

    osfic_mul u_mul (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (mul_req),
        .i_sh_const (i_ctrl.op == OP_MULC),
        .i_a        (a_val),
        .i_b        (b_val),
        .o_done     (mul_done),
        .o_res      (mul_res)
    );

    // saturating add / subtract, one extra bit catches the overflow
    always_comb begin
        if (i_ctrl.op == OP_SUB) begin
            sum = {a_val[DW-1], a_val} - {b_val[DW-1], b_val};
        end else begin
            sum = {a_val[DW-1], a_val} + {b_val[DW-1], b_val};
        end
        case (i_ctrl.op)
            OP_ADD, OP_SUB: begin
                if (sum[DW] != sum[DW-1]) begin
                    wr_val = sum[DW] ? D_MIN : D_MAX;
                end else begin
                    wr_val = sum[DW-1:0];
                end
            end
            OP_MULQ, OP_MULC: wr_val = mul_res;
            default:          wr_val = a_val;
        endcase
    end

    assign y_prod   = YP_W'(i_adc_sample) * YP_W'(C_ADC_K);
    assign out_free = !r_out_valid || i_out_ready;
    assign cnt_bits = r_t1[DW-1:FRAC_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_low   <= RST_REF_LOW;
            r_ref_high  <= RST_REF_HIGH;
            r_ki        <= RST_KI;
            r_k1        <= RST_K1;
            r_k2        <= RST_K2;
            r_k3        <= RST_K3;
            r_dmax      <= RST_DMAX;
            r_pwm_scale <= RST_PWM;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_REF_LOW:   r_ref_low   <= i_cfg_data;
                CFG_REF_HIGH:  r_ref_high  <= i_cfg_data;
                CFG_KI:        r_ki        <= i_cfg_data;
                CFG_K1:        r_k1        <= i_cfg_data;
                CFG_K2:        r_k2        <= i_cfg_data;
                CFG_K3:        r_k3        <= i_cfg_data;
                CFG_DRIVE_MAX: r_dmax      <= i_cfg_data[DRIVE_W-1:0];
                CFG_PWM_SCALE: r_pwm_scale <= i_cfg_data[DRIVE_W-1:0];
                default: ;
            endcase
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eta0  <= '0;
            r_eta1  <= '0;
            r_xi    <= '0;
            r_ulast <= RST_ULAST;
        end else if (i_ctrl.commit) begin
            case (i_ctrl.dst)
                D_ETA0:  r_eta0  <= wr_val;
                D_ETA1:  r_eta1  <= wr_val;
                D_XI:    r_xi    <= wr_val;
                D_ULAST: r_ulast <= wr_val;
                default: ;
            endcase
        end
    end

    // scratch and sample registers
    always_ff @(posedge i_clk) begin
        if (i_ctrl.commit) begin
            case (i_ctrl.dst)
                D_T0:    r_t0 <= wr_val;
                D_T1:    r_t1 <= wr_val;
                D_T2:    r_t2 <= wr_val;
                default: ;
            endcase
            if (i_ctrl.op == OP_LOAD) begin
                r_y <= DW'(y_prod >> ADC_SHIFT);
                r_r <= i_ref_select ? r_ref_high : r_ref_low;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.commit && i_ctrl.op == OP_EMIT) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_ctrl.commit && i_ctrl.op == OP_EMIT) begin
            r_drive <= r_t0[DRIVE_W-1:0];
            r_pwm   <= (|cnt_bits[CNT_HI-1:PWM_W]) ? {PWM_W{1'b1}} : cnt_bits[PWM_W-1:0];
        end
    end

    assign o_stat.mul_done = mul_done;
    assign o_stat.out_free = out_free;
    assign o_stat.a_neg    = a_val[DW-1];
    assign o_stat.a_le_b   = (a_val <= b_val);

    assign o_out_valid   = r_out_valid;
    assign o_drive_value = r_drive;
    assign o_pwm_compare = r_pwm;

endmodule

// ===== hw/rtl/osfic_useq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osfic_useq
// step counter and control store of the update program
// ----------------------------------------------------------------------------
module osfic_useq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  osfic_pkg::t_stat i_stat,
    output osfic_pkg::t_ctrl o_ctrl
);
    import osfic_pkg::*;

    localparam logic [5:0] L_WAIT  = 6'd0;
    localparam logic [5:0] L_ZERO  = 6'd36;
    localparam logic [5:0] L_STORE = 6'd37;

    logic [5:0] r_pc, n_pc;
    t_uword     uw;
    logic       stall, taken;

    function automatic t_uword mk(input t_op op, input t_src a, input t_src b,
                                  input t_dst d, input t_jmp j, input logic [5:0] tg);
        t_uword w;
        w.op     = op;
        w.src_a  = a;
        w.src_b  = b;
        w.dst    = d;
        w.jmp    = j;
        w.target = tg;
        return w;
    endfunction

    function automatic t_uword rom(input logic [5:0] pc);
        t_uword w;
        case (pc)
            // sample load, then observer derivative, first state
            6'd0:  w = mk(OP_LOAD, S_ZERO,  S_ZERO, D_NONE,  J_NEXT, L_WAIT);
            6'd1:  w = mk(OP_MULC, S_ULAST, S_F0,   D_T0,    J_NEXT, L_WAIT);
            6'd2:  w = mk(OP_MULC, S_Y,     S_B0,   D_T1,    J_NEXT, L_WAIT);
            6'd3:  w = mk(OP_ADD,  S_T0,    S_T1,   D_T0,    J_NEXT, L_WAIT);
            6'd4:  w = mk(OP_MULC, S_ETA0,  S_A00,  D_T1,    J_NEXT, L_WAIT);
            6'd5:  w = mk(OP_ADD,  S_T0,    S_T1,   D_T0,    J_NEXT, L_WAIT);
            6'd6:  w = mk(OP_MULC, S_ETA1,  S_A01,  D_T1,    J_NEXT, L_WAIT);
            6'd7:  w = mk(OP_ADD,  S_T0,    S_T1,   D_T0,    J_NEXT, L_WAIT);
            // second state
            6'd8:  w = mk(OP_MULC, S_ULAST, S_F1,   D_T2,    J_NEXT, L_WAIT);
            6'd9:  w = mk(OP_MULC, S_Y,     S_B1,   D_T1,    J_NEXT, L_WAIT);
            6'd10: w = mk(OP_ADD,  S_T2,    S_T1,   D_T2,    J_NEXT, L_WAIT);
            6'd11: w = mk(OP_MULC, S_ETA0,  S_A10,  D_T1,    J_NEXT, L_WAIT);
            6'd12: w = mk(OP_ADD,  S_T2,    S_T1,   D_T2,    J_NEXT, L_WAIT);
            6'd13: w = mk(OP_MULC, S_ETA1,  S_A11,  D_T1,    J_NEXT, L_WAIT);
            6'd14: w = mk(OP_ADD,  S_T2,    S_T1,   D_T2,    J_NEXT, L_WAIT);
            // euler step
            6'd15: w = mk(OP_MULC, S_T0,    S_TS,   D_T0,    J_NEXT, L_WAIT);
            6'd16: w = mk(OP_ADD,  S_ETA0,  S_T0,   D_ETA0,  J_NEXT, L_WAIT);
            6'd17: w = mk(OP_MULC, S_T2,    S_TS,   D_T2,    J_NEXT, L_WAIT);
            6'd18: w = mk(OP_ADD,  S_ETA1,  S_T2,   D_ETA1,  J_NEXT, L_WAIT);
            // full state estimate
            6'd19: w = mk(OP_MULC, S_Y,     S_D0,   D_T0,    J_NEXT, L_WAIT);
            6'd20: w = mk(OP_ADD,  S_ETA0,  S_T0,   D_T0,    J_NEXT, L_WAIT);
            6'd21: w = mk(OP_MULC, S_Y,     S_D1,   D_T1,    J_NEXT, L_WAIT);
            6'd22: w = mk(OP_ADD,  S_ETA1,  S_T1,   D_T1,    J_NEXT, L_WAIT);
            // integral of tracking error
            6'd23: w = mk(OP_SUB,  S_R,     S_Y,    D_T2,    J_NEXT, L_WAIT);
            6'd24: w = mk(OP_MULC, S_T2,    S_TS,   D_T2,    J_NEXT, L_WAIT);
            6'd25: w = mk(OP_ADD,  S_XI,    S_T2,   D_XI,    J_NEXT, L_WAIT);
            // feedback sum and effort
            6'd26: w = mk(OP_MULQ, S_K1,    S_Y,    D_T2,    J_NEXT, L_WAIT);
            6'd27: w = mk(OP_MULQ, S_K2,    S_T0,   D_T0,    J_NEXT, L_WAIT);
            6'd28: w = mk(OP_ADD,  S_T2,    S_T0,   D_T2,    J_NEXT, L_WAIT);
            6'd29: w = mk(OP_MULQ, S_K3,    S_T1,   D_T1,    J_NEXT, L_WAIT);
            6'd30: w = mk(OP_ADD,  S_T2,    S_T1,   D_T2,    J_NEXT, L_WAIT);
            6'd31: w = mk(OP_MULQ, S_KI,    S_XI,   D_T0,    J_NEXT, L_WAIT);
            6'd32: w = mk(OP_SUB,  S_T0,    S_T2,   D_T0,    J_NEXT, L_WAIT);
            // clamp to [0, drive_max], store the drive, scale it to the compare value and emit
            6'd33: w = mk(OP_NOP,  S_T0,    S_ZERO, D_NONE,  J_NEG,  L_ZERO);
            6'd34: w = mk(OP_NOP,  S_T0,    S_DMAX, D_NONE,  J_LE,   L_STORE);
            6'd35: w = mk(OP_MOV,  S_DMAX,  S_ZERO, D_T0,    J_GOTO, L_STORE);
            6'd36: w = mk(OP_MOV,  S_ZERO,  S_ZERO, D_T0,    J_NEXT, L_WAIT);
            6'd37: w = mk(OP_MOV,  S_T0,    S_ZERO, D_ULAST, J_NEXT, L_WAIT);
            6'd38: w = mk(OP_MULQ, S_PWM,   S_T0,   D_T1,    J_NEXT, L_WAIT);
            6'd39: w = mk(OP_EMIT, S_ZERO,  S_ZERO, D_NONE,  J_GOTO, L_WAIT);
            default: w = mk(OP_NOP, S_ZERO, S_ZERO, D_NONE,  J_GOTO, L_WAIT);
        endcase
        return w;
    endfunction

    assign uw = rom(r_pc);

    always_comb begin
        case (uw.op)
            OP_LOAD:          stall = !i_in_valid;
            OP_EMIT:          stall = !i_stat.out_free;
            OP_MULQ, OP_MULC: stall = !i_stat.mul_done;
            default:          stall = 1'b0;
        endcase
        unique case (uw.jmp)
            J_NEXT:  taken = 1'b0;
            J_GOTO:  taken = 1'b1;
            J_NEG:   taken = i_stat.a_neg;
            J_LE:    taken = i_stat.a_le_b;
            default: taken = 1'b0;
        endcase
        if (stall) begin
            n_pc = r_pc;
        end else if (taken) begin
            n_pc = uw.target;
        end else begin
            n_pc = r_pc + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= L_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_in_ready    = (uw.op == OP_LOAD);
    assign o_ctrl.op     = uw.op;
    assign o_ctrl.src_a  = uw.src_a;
    assign o_ctrl.src_b  = uw.src_b;
    assign o_ctrl.dst    = uw.dst;
    assign o_ctrl.commit = !stall;

endmodule

// ===== hw/rtl/osfic_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osfic_chk
// port-level checks of the controller, bound to the top level
// ----------------------------------------------------------------------------
module osfic_chk (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             i_in_ready,
    input logic                             i_out_valid,
    input logic                             i_out_ready,
    input logic [osfic_pkg::DRIVE_W-1:0]    i_drive,
    input logic [osfic_pkg::PWM_W-1:0]      i_pwm
);

    // a held result word keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_drive) && $stable(i_pwm))
        else $error("result word changed while stalled");

    // one sample at a time: no second word the cycle after one is taken
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("sample taken while busy");

    // reset drops the output word
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // zero drive gives a zero compare value
    a_zero_pwm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_drive == '0) |-> (i_pwm == '0))
        else $error("compare value without drive");

endmodule

bind observer_state_feedback_integral_ctrl osfic_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_smp.valid),
    .i_in_ready  (i_smp.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_drive     (o_res.drive_value),
    .i_pwm       (o_res.pwm_compare)
);

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the observer controller: a directed table of
// sample and register words, then random phases under varied register
// settings; result words are checked against table words or a cycle-free predictor
// ----------------------------------------------------------------------------
module tb;
    import osfic_pkg::*;

    typedef logic [DW-1:0] t_dword;

    typedef struct packed {
        logic [DRIVE_W-1:0] drive;
        logic [PWM_W-1:0]   pwm;
    } t_drive_word;

    typedef enum logic { ROW_SAMPLE, ROW_WRITE } t_row_kind;
    typedef enum logic { CHK_MODEL, CHK_TABLE } t_chk;
    typedef enum logic [2:0] { SET_DEFAULT, SET_PLANT, SET_WILD, SET_TOP, SET_BOTTOM } t_set_kind;

    typedef struct packed {
        t_row_kind          kind;
        t_cfg_idx           idx;
        t_dword             data;
        logic [11:0]        adc;
        logic               sel;
        t_chk               chk;
        logic [DRIVE_W-1:0] drive;
        logic [PWM_W-1:0]   pwm;
    } t_dir_row;

    // fraction bits of data words and of plant constants
    localparam int Q_DATA  = 24;
    localparam int Q_PLANT = 32;

    localparam t_dword WORD_MAX = 48'h7FFF_FFFF_FFFF;
    localparam t_dword WORD_MIN = 48'h8000_0000_0000;

    // plant constants, 32 fraction bits
    localparam t_dword PL_TS  = 48'sd2147484;
    localparam t_dword PL_ADC = 48'sd3460301;
    localparam t_dword PL_A00 = 48'sd416523780882;
    localparam t_dword PL_A01 = 48'sd38701520808;
    localparam t_dword PL_A10 = -48'sd69487846385254;
    localparam t_dword PL_A11 = -48'sd2863311530667;
    localparam t_dword PL_B0  = 48'sd51252274;
    localparam t_dword PL_B1  = -48'sd3382517815;
    localparam t_dword PL_F0  = 48'sd0;
    localparam t_dword PL_F1  = 48'sd286332585;
    localparam t_dword PL_D0  = -48'sd77258;
    localparam t_dword PL_D1  = 48'sd6948828;

    // register defaults, in index order
    localparam t_dword REG_DEFAULT [8] = '{
        48'd16777216, 48'd25165824, 48'd23360595558, 48'd184274230,
        48'd7838768300032, 48'd10484568818, 48'd55364813, 48'd5078919623
    };

    localparam int PHASE_ITEMS   = 66;
    localparam int SETTLE_CYCLES = 100;

    localparam t_set_kind PHASE_KINDS [8] = '{
        SET_PLANT, SET_WILD, SET_PLANT, SET_TOP,
        SET_PLANT, SET_BOTTOM, SET_DEFAULT, SET_WILD
    };

    // directed table; drive limit zero and all-zero gains give a known word
    localparam int DIR_N = 34;
    localparam t_dir_row DIR_ROWS [DIR_N] = '{
        '{ROW_SAMPLE, CFG_REF_LOW,   48'h0, 12'h000, 1'b0, CHK_MODEL, 47'd0, 16'd0},
        '{ROW_SAMPLE, CFG_REF_LOW,   48'h0, 12'hFFF, 1'b1, CHK_MODEL, 47'd0, 16'd0},
        '{ROW_SAMPLE, CFG_REF_LOW,   48'h0, 12'hAAA, 1'b0, CHK_MODEL, 47'd0, 16'd0},
        '{ROW_SAMPLE, CFG_REF_LOW,   48'h0, 12'h555, 1'b1, CHK_MODEL, 47'd0, 16'd0},
        '{ROW_SAMPLE, CFG_REF_LOW,   48'h0, 12'h800, 1'b1, CHK_MODEL, 47'd0, 16'd0},
        '{ROW_SAMPLE, CFG_REF_LOW,   48'h0, 12'h7FF, 1'b0, CHK_MODEL, 47'd0, 16'd0},
        '{ROW_WRITE,  CFG_DRIVE_MAX, 48'h0, 12'h000, 1'b0, CHK_MODEL, 47'd0, 16'd0},
        '{ROW_SAMPLE, CFG_REF_LOW,   48'h0, 12'hFFF, 1'b1, CHK_TABLE, 47'd0, 16'd0},
        '{ROW_SAMPLE, CFG_REF_LOW,   48'h0, 12'h000, 1'b0, CHK_TABLE, 47'd0, 16'd0},
        '{ROW_WRITE,  CFG_DRIVE_MAX, 48'hFFFF_FFFF_FFFF, 12'h0, 1'b0, CHK_MODEL, 47'd0, 16'd0},
        '{ROW_WRITE,  CFG_PWM_SCALE, 48'hFFFF_FFFF_FFFF, 12'h0, 1'b0, CHK_MODEL, 47'd0, 16'd0},
        '{ROW_WRITE,  CFG_K1,        48'h0, 12'h000, 1'b0, CHK_MODEL, 47'd0, 16'd0},
        '{ROW_WRITE,  CFG_K2,        48'h0, 12'h000, 1'b0, CHK_MODEL, 47'd0, 16'd0},
        '{ROW_WRITE,  CFG_K3,        48'h0, 12'h000, 1'b0, CHK_MODEL, 47'd0, 16'd0},
        '{ROW_WRITE,  CFG_REF_HIGH,  WORD_MAX, 12'h0, 1'b0, CHK_MODEL, 47'd0, 16'd0},
        '{ROW_WRITE,  CFG_KI,        WORD_MAX, 12'h0, 1'b0, CHK_MODEL, 47'd0, 16'd0},
        '{ROW_SAMPLE, CFG_REF_LOW,   48'h0, 12'h000, 1'b1, CHK_MODEL, 47'd0, 16'd0},
        '{ROW_SAMPLE, CFG_REF_LOW,   48'h0, 12'h000, 1'b1, CHK_MODEL, 47'd0, 16'd0},
        '{ROW_SAMPLE, CFG_REF_LOW,   48'h0, 12'h000, 1'b1, CHK_MODEL, 47'd0, 16'd0},
        '{ROW_WRITE,  CFG_KI,        WORD_MIN, 12'h0, 1'b0, CHK_MODEL, 47'd0, 16'd0},
        '{ROW_SAMPLE, CFG_REF_LOW,   48'h0, 12'h000, 1'b1, CHK_MODEL, 47'd0, 16'd0},
        '{ROW_WRITE,  CFG_KI,        48'h0, 12'h000, 1'b0, CHK_MODEL, 47'd0, 16'd0},
        '{ROW_SAMPLE, CFG_REF_LOW,   48'h0, 12'hFFF, 1'b0, CHK_TABLE, 47'd0, 16'd0},
        '{ROW_WRITE,  CFG_REF_LOW,   WORD_MIN, 12'h0, 1'b0, CHK_MODEL, 47'd0, 16'd0},
        '{ROW_WRITE,  CFG_K1,        WORD_MIN, 12'h0, 1'b0, CHK_MODEL, 47'd0, 16'd0},
        '{ROW_WRITE,  CFG_K2,        WORD_MAX, 12'h0, 1'b0, CHK_MODEL, 47'd0, 16'd0},
        '{ROW_WRITE,  CFG_K3,        WORD_MIN, 12'h0, 1'b0, CHK_MODEL, 47'd0, 16'd0},
        '{ROW_WRITE,  CFG_KI,        WORD_MAX, 12'h0, 1'b0, CHK_MODEL, 47'd0, 16'd0},
        '{ROW_SAMPLE, CFG_REF_LOW,   48'h0, 12'hFFF, 1'b0, CHK_MODEL, 47'd0, 16'd0},
        '{ROW_SAMPLE, CFG_REF_LOW,   48'h0, 12'h000, 1'b0, CHK_MODEL, 47'd0, 16'd0},
        '{ROW_SAMPLE, CFG_REF_LOW,   48'h0, 12'h001, 1'b0, CHK_MODEL, 47'd0, 16'd0},
        '{ROW_WRITE,  CFG_PWM_SCALE, 48'h0, 12'h000, 1'b0, CHK_MODEL, 47'd0, 16'd0},
        '{ROW_SAMPLE, CFG_REF_LOW,   48'h0, 12'h123, 1'b1, CHK_MODEL, 47'd0, 16'd0},
        '{ROW_SAMPLE, CFG_REF_LOW,   48'h0, 12'hE5A, 1'b0, CHK_MODEL, 47'd0, 16'd0}
    };

    logic     i_clk = 1'b0;
    logic     i_rst_n;
    logic     cfg_we;
    t_cfg_idx cfg_idx;
    t_dword   cfg_data;

    osfic_smp_if smp_if ();
    osfic_res_if res_if ();

    observer_state_feedback_integral_ctrl u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_smp      (smp_if),
        .o_res      (res_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // predictor copy of registers and controller state
    t_dword reg_val [8];
    t_dword eta0, eta1, err_int, drive_prev;

    // result words still owed by the block, oldest first
    t_drive_word owed_words [$];
    int          mismatches = 0;
    bit          sink_calm  = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // exact signed product, shifted with truncation toward zero, saturated
    function automatic t_dword scaled_mul(input t_dword a, input t_dword b, input int sh);
        t_dword      ma;
        t_dword      mb;
        logic [95:0] mag;
        ma  = a[DW-1] ? (~a + 48'd1) : a;
        mb  = b[DW-1] ? (~b + 48'd1) : b;
        mag = ({48'd0, ma} * {48'd0, mb}) >> sh;
        if (a[DW-1] ^ b[DW-1]) begin
            if (mag >= {48'd0, WORD_MIN}) return WORD_MIN;
            return ~mag[DW-1:0] + 48'd1;
        end
        if (mag > {48'd0, WORD_MAX}) return WORD_MAX;
        return mag[DW-1:0];
    endfunction

    function automatic t_dword sat_add(input t_dword a, input t_dword b);
        logic [DW:0] s;
        s = {a[DW-1], a} + {b[DW-1], b};
        if (s[DW] != s[DW-1]) return s[DW] ? WORD_MIN : WORD_MAX;
        return s[DW-1:0];
    endfunction

    function automatic t_dword sat_sub(input t_dword a, input t_dword b);
        logic [DW:0] s;
        s = {a[DW-1], a} - {b[DW-1], b};
        if (s[DW] != s[DW-1]) return s[DW] ? WORD_MIN : WORD_MAX;
        return s[DW-1:0];
    endfunction

    function automatic void reset_controller();
        for (int k = 0; k < 8; k++) reg_val[k] = REG_DEFAULT[k];
        eta0       = '0;
        eta1       = '0;
        err_int    = '0;
        drive_prev = 48'd1 << Q_DATA;
    endfunction

    // one sample tick of the controller: observer, integral, feedback, clamp
    function automatic t_drive_word advance_controller(input logic [11:0] adc, input logic sel);
        t_dword      y, r, d0, d1, x1, x2, kx, u, pw;
        t_drive_word w;
        y  = (48'(adc) * PL_ADC) >> (Q_PLANT - Q_DATA);
        r  = sel ? reg_val[CFG_REF_HIGH] : reg_val[CFG_REF_LOW];

        // observer derivative uses the states from before this tick
        d0 = sat_add(scaled_mul(drive_prev, PL_F0, Q_PLANT), scaled_mul(y, PL_B0, Q_PLANT));
        d0 = sat_add(d0, scaled_mul(eta0, PL_A00, Q_PLANT));
        d0 = sat_add(d0, scaled_mul(eta1, PL_A01, Q_PLANT));
        d1 = sat_add(scaled_mul(drive_prev, PL_F1, Q_PLANT), scaled_mul(y, PL_B1, Q_PLANT));
        d1 = sat_add(d1, scaled_mul(eta0, PL_A10, Q_PLANT));
        d1 = sat_add(d1, scaled_mul(eta1, PL_A11, Q_PLANT));
        eta0 = sat_add(eta0, scaled_mul(d0, PL_TS, Q_PLANT));
        eta1 = sat_add(eta1, scaled_mul(d1, PL_TS, Q_PLANT));

        // full state estimate
        x1 = sat_add(eta0, scaled_mul(y, PL_D0, Q_PLANT));
        x2 = sat_add(eta1, scaled_mul(y, PL_D1, Q_PLANT));

        err_int = sat_add(err_int, scaled_mul(sat_sub(r, y), PL_TS, Q_PLANT));

        kx = scaled_mul(reg_val[CFG_K1], y, Q_DATA);
        kx = sat_add(kx, scaled_mul(reg_val[CFG_K2], x1, Q_DATA));
        kx = sat_add(kx, scaled_mul(reg_val[CFG_K3], x2, Q_DATA));
        u  = sat_sub(scaled_mul(reg_val[CFG_KI], err_int, Q_DATA), kx);

        // clamp to [0, drive_max]
        if (u[DW-1]) u = '0;
        if (u > reg_val[CFG_DRIVE_MAX]) u = reg_val[CFG_DRIVE_MAX];
        drive_prev = u;

        pw      = scaled_mul(reg_val[CFG_PWM_SCALE], u, Q_DATA);
        w.drive = u[DRIVE_W-1:0];
        w.pwm   = (pw[DW-1:Q_DATA] > 24'd65535) ? 16'hFFFF : pw[Q_DATA+15:Q_DATA];
        return w;
    endfunction

    // drop valid and hold off until every owed word has come back
    task automatic wait_results_done();
        smp_if.valid <= 1'b0;
        do @(posedge i_clk); while (owed_words.size() != 0);
    endtask

    // one register write; the two drive-related registers keep 47 bits
    task automatic program_reg(input t_cfg_idx idx, input t_dword data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_DRIVE_MAX, CFG_PWM_SCALE: begin
                reg_val[idx] = {1'b0, data[DW-2:0]};
            end
            default: begin
                reg_val[idx] = data;
            end
        endcase
    endtask

    // offer one sample word, predict its result when it is taken
    task automatic send_sample(input logic [11:0] adc, input logic sel,
                               input bit typed, input t_drive_word typed_word);
        t_drive_word w;
        cfg_we            <= 1'b0;
        smp_if.valid      <= 1'b1;
        smp_if.adc_sample <= adc;
        smp_if.ref_select <= sel;
        do @(posedge i_clk); while (!smp_if.ready);
        w = advance_controller(adc, sel);
        owed_words.push_back(typed ? typed_word : w);
    endtask

    // result side: check each taken word, stall on a pattern of its own
    initial begin : result_side
        int          hold;
        t_drive_word want;
        hold = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (res_if.valid && res_if.ready) begin
                if (owed_words.size() == 0) begin
                    mismatches++;
                    $display("%0t: result word with nothing expected: drive %h pwm %h",
                             $time, res_if.drive_value, res_if.pwm_compare);
                end else begin
                    want = owed_words.pop_front();
                    if (res_if.drive_value !== want.drive) begin
                        mismatches++;
                        $display("%0t: drive_value expected %h actual %h",
                                 $time, want.drive, res_if.drive_value);
                    end
                    if (res_if.pwm_compare !== want.pwm) begin
                        mismatches++;
                        $display("%0t: pwm_compare expected %h actual %h",
                                 $time, want.pwm, res_if.pwm_compare);
                    end
                end
            end
            if (hold != 0) begin
                hold--;
            end else if (sink_calm) begin
                res_if.ready <= 1'b1;
            end else if (res_if.ready) begin
                res_if.ready <= 1'b0;
                hold = $urandom_range(0, 24);
            end else begin
                res_if.ready <= 1'b1;
                hold = $urandom_range(0, 30);
            end
        end
    end

    // run limit
    initial begin
        #4_000_000;
        $display("tb failed");
        $finish;
    end

    initial begin : stimulus
        t_dword      vals [8];
        t_set_kind   kind;
        t_dir_row    row;
        int          lvl;
        int          burst_left;
        bit          src_calm;
        logic [11:0] adc;
        logic        sel;
        longint      scaled;

        lvl        = 1241;
        burst_left = 0;
        sel        = 1'b0;

        // everything known from time zero, reset held before the run starts
        i_rst_n           <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_idx           <= CFG_REF_LOW;
        cfg_data          <= '0;
        smp_if.valid      <= 1'b0;
        smp_if.adc_sample <= '0;
        smp_if.ref_select <= 1'b0;
        reset_controller();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table: register rows only once the block is idle
        for (int i = 0; i < DIR_N; i++) begin
            row = DIR_ROWS[i];
            if (row.kind == ROW_WRITE) begin
                wait_results_done();
                program_reg(row.idx, row.data);
            end else begin
                send_sample(row.adc, row.sel, row.chk == CHK_TABLE, {row.drive, row.pwm});
            end
        end

        // random phases, each under a fresh register setting
        for (int p = 0; p < 8; p++) begin
            kind = PHASE_KINDS[p];
            for (int k = 0; k < 8; k++) begin
                case (kind)
                    SET_DEFAULT: begin
                        vals[k] = REG_DEFAULT[k];
                    end
                    SET_PLANT: begin
                        // around the plant design point, references within 0..3.3 V
                        scaled  = longint'(REG_DEFAULT[k]) * longint'($urandom_range(50, 150));
                        vals[k] = 48'(scaled / 100);
                        if (k == CFG_REF_LOW || k == CFG_REF_HIGH)
                            vals[k] = 48'($urandom_range(0, 55364813));
                        if (k == CFG_DRIVE_MAX)
                            vals[k] = 48'($urandom_range(16777216, 83886080));
                    end
                    SET_WILD: begin
                        vals[k] = 48'({$urandom, $urandom});
                    end
                    SET_TOP: begin
                        vals[k] = (k >= CFG_DRIVE_MAX) ? 48'hFFFF_FFFF_FFFF : WORD_MAX;
                    end
                    default: begin
                        // drive limit word with only its ignored top bit set
                        vals[k] = (k == CFG_PWM_SCALE) ? 48'd1 : WORD_MIN;
                    end
                endcase
            end
            wait_results_done();
            for (int k = 0; k < 8; k++) program_reg(t_cfg_idx'(k), vals[k]);

            sink_calm = (p == 2) || ($urandom_range(0, 3) == 0);
            src_calm  = (p == 2) || ($urandom_range(0, 3) == 0);

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (burst_left == 0) begin
                    if ($urandom_range(0, 15) == 0) begin
                        wait_results_done();
                    end else if (!src_calm) begin
                        smp_if.valid <= 1'b0;
                        repeat ($urandom_range(1, 40)) @(posedge i_clk);
                    end
                    burst_left = $urandom_range(1, 12);
                end
                burst_left--;
                if (kind == SET_PLANT) begin
                    // slowly moving measurement with the odd step change
                    if ($urandom_range(0, 9) == 0) begin
                        lvl = $urandom_range(0, 4095);
                    end else begin
                        lvl += int'($urandom_range(0, 80)) - 40;
                        if (lvl < 0) lvl = 0;
                        if (lvl > 4095) lvl = 4095;
                    end
                    if ($urandom_range(0, 9) == 0) sel = ~sel;
                    adc = 12'(lvl);
                end else begin
                    adc = 12'($urandom_range(0, 4095));
                    sel = 1'($urandom_range(0, 1));
                end
                send_sample(adc, sel, 1'b0, '0);
            end
        end

        // drain, then give the block one more update time to misbehave
        wait_results_done();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && owed_words.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

// ===== observer_state_feedback_integral_ctrl.f =====
hw/rtl/osfic_pkg.sv
hw/rtl/osfic_smp_if.sv
hw/rtl/osfic_res_if.sv
hw/rtl/osfic_mul.sv
hw/rtl/osfic_dp.sv
hw/rtl/osfic_useq.sv
hw/rtl/observer_state_feedback_integral_ctrl.sv
hw/rtl/osfic_chk.sv
verif/tb.sv
